[rtl/assert_macros.svh]
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset.
`define ASSERT_RUN(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Checked at every edge, reset included.
`define ASSERT_ALL(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

[rtl/ttb_pkg.sv]
package ttb_pkg;

    localparam int IdxW = 20;
    localparam int FixW = 32;

    typedef logic signed [FixW-1:0] t_fix;

    // one triangle handed from the front part to the back part
    typedef struct packed {
        logic [IdxW-1:0] idx_a;
        logic [IdxW-1:0] idx_b;
        logic [IdxW-1:0] idx_c;
        t_fix [2:0]      e0;
        t_fix [2:0]      e1;
        t_fix            u1;
        t_fix            v1;
        t_fix            u2;
        t_fix            v2;
    } t_job;

    typedef struct packed {
        logic [IdxW-1:0] idx_a;
        logic [IdxW-1:0] idx_b;
        logic [IdxW-1:0] idx_c;
        t_fix [2:0]      tangent;
        t_fix [2:0]      binormal;
        logic            degenerate;
    } t_result;

    function automatic t_fix sat32(input logic signed [FixW:0] v);
        logic [FixW-1:0] r;
        if (v[FixW] != v[FixW-1]) begin
            r = v[FixW] ? {1'b1, {(FixW-1){1'b0}}} : {1'b0, {(FixW-1){1'b1}}};
        end else begin
            r = v[FixW-1:0];
        end
        return t_fix'(r);
    endfunction

endpackage

[rtl/ttb_front.sv]
module ttb_front #(
    parameter int INDEX_BITS = 20
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [ttb_pkg::IdxW-1:0]      i_index,
    input  ttb_pkg::t_fix [2:0]           i_pos,
    input  ttb_pkg::t_fix [1:0]           i_tex,
    input  logic                          i_full,
    output logic                          o_push,
    output ttb_pkg::t_job                 o_job
);

    localparam logic [ttb_pkg::IdxW-1:0] IdxMask = (INDEX_BITS >= ttb_pkg::IdxW) ?
        {ttb_pkg::IdxW{1'b1}} : ttb_pkg::IdxW'((64'd1 << INDEX_BITS) - 64'd1);

    logic [1:0]                 r_count;
    logic [1:0]                 n_count;
    logic [ttb_pkg::IdxW-1:0]   r_idx [2];
    ttb_pkg::t_fix [2:0]        r_pos [2];
    ttb_pkg::t_fix [1:0]        r_tex [2];
    logic                       take;
    logic [ttb_pkg::IdxW-1:0]   idx_m;

    assign o_ready = (r_count != 2'd2) || !i_full;
    assign take    = i_valid && o_ready;
    assign o_push  = take && (r_count == 2'd2);
    assign idx_m   = i_index & IdxMask;

    always_comb begin
        n_count = r_count;
        if (take) begin
            n_count = (r_count == 2'd2) ? 2'd0 : r_count + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 2'd0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && r_count != 2'd2) begin
            r_idx[r_count[0]] <= idx_m;
            r_pos[r_count[0]] <= i_pos;
            r_tex[r_count[0]] <= i_tex;
        end
    end

    // deltas from corner one, each clamped to 32 bits
    always_comb begin
        o_job.idx_a = r_idx[0];
        o_job.idx_b = r_idx[1];
        o_job.idx_c = idx_m;
        for (int k = 0; k < 3; k++) begin
            o_job.e0[k] = ttb_pkg::sat32({r_pos[1][k][31], r_pos[1][k]}
                                       - {r_pos[0][k][31], r_pos[0][k]});
            o_job.e1[k] = ttb_pkg::sat32({i_pos[k][31], i_pos[k]}
                                       - {r_pos[0][k][31], r_pos[0][k]});
        end
        o_job.u1 = ttb_pkg::sat32({r_tex[1][0][31], r_tex[1][0]} - {r_tex[0][0][31], r_tex[0][0]});
        o_job.v1 = ttb_pkg::sat32({r_tex[1][1][31], r_tex[1][1]} - {r_tex[0][1][31], r_tex[0][1]});
        o_job.u2 = ttb_pkg::sat32({i_tex[0][31], i_tex[0]} - {r_tex[0][0][31], r_tex[0][0]});
        o_job.v2 = ttb_pkg::sat32({i_tex[1][31], i_tex[1]} - {r_tex[0][1][31], r_tex[0][1]});
    end

endmodule

[rtl/ttb_fifo.sv]
module ttb_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  ttb_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output ttb_pkg::t_job o_job
);

    ttb_pkg::t_job r_mem [2];
    logic          r_wp;
    logic          r_rp;
    logic [1:0]    r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_job;
    end

endmodule

[rtl/ttb_back.sv]
module ttb_back #(
    parameter int FRAC_BITS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_empty,
    input  ttb_pkg::t_job     i_job,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_ready,
    output ttb_pkg::t_result  o_res
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MUL  = 4'b0010,
        S_DIV  = 4'b0100,
        S_OUT  = 4'b1000
    } t_state;

    localparam logic [3:0] LastStep = 4'd13;

    t_state                r_state;
    t_state                n_state;
    ttb_pkg::t_job         r_job;
    logic [3:0]            r_step;
    logic                  r_pv;
    logic [3:0]            r_pstep;
    logic signed [63:0]    r_prod;
    logic signed [63:0]    r_first;
    logic [64:0]           r_num [7];
    logic [2:0]            r_j;
    logic                  r_load;
    logic [63:0]           r_rem;
    logic [31:0]           r_lo;
    logic [31:0]           r_q;
    logic [4:0]            r_cnt;
    logic                  r_neg;
    ttb_pkg::t_fix         r_res [6];
    logic                  r_valid;
    ttb_pkg::t_result      r_out;

    logic signed [31:0]    op_a;
    logic signed [31:0]    op_b;
    logic [64:0]           num;
    logic [64:0]           den;
    logic [63:0]           mag_n;
    logic [63:0]           mag_d;
    logic [63:0]           hi_part;
    logic [64:0]           shifted;
    logic [31:0]           q_next;
    ttb_pkg::t_fix         sat_val;
    ttb_pkg::t_fix         fin_val;
    logic                  det_zero;
    logic                  out_free;

    assign o_pop   = (r_state == S_IDLE) && !i_empty;
    assign o_valid = r_valid;
    assign o_res   = r_out;
    assign out_free = !r_valid || i_ready;

    // operand pairs: det, then tangent x..z, then binormal x..z; each is first minus second
    always_comb begin
        op_a = '0;
        op_b = '0;
        case (r_step[3:1])
            3'd0: begin
                op_a = r_step[0] ? r_job.u1 : r_job.u2;
                op_b = r_step[0] ? r_job.v2 : r_job.v1;
            end
            3'd1, 3'd2, 3'd3: begin
                op_a = r_step[0] ? r_job.e0[r_step[3:1] - 3'd1] : r_job.e1[r_step[3:1] - 3'd1];
                op_b = r_step[0] ? r_job.v2 : r_job.v1;
            end
            3'd4, 3'd5, 3'd6: begin
                op_a = r_step[0] ? r_job.e1[r_step[3:1] - 3'd4] : r_job.e0[r_step[3:1] - 3'd4];
                op_b = r_step[0] ? r_job.u1 : r_job.u2;
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    always_comb begin
        num      = r_num[r_j + 3'd1];
        den      = r_num[0];
        det_zero = (den == '0);
        mag_n    = num[64] ? 64'(65'd0 - num) : num[63:0];
        mag_d    = den[64] ? 64'(65'd0 - den) : den[63:0];
        hi_part  = 64'(mag_n >> (32 - FRAC_BITS));
        sat_val  = (num[64] != den[64]) ? 32'sh8000_0000 : 32'sh7fff_ffff;
        shifted  = {r_rem, r_lo[31]};
        q_next   = {r_q[30:0], (shifted >= {1'b0, mag_d})};
        if (r_neg) begin
            fin_val = q_next[31] ? 32'sh8000_0000 : ttb_pkg::t_fix'(32'd0 - q_next);
        end else begin
            fin_val = q_next[31] ? 32'sh7fff_ffff : ttb_pkg::t_fix'(q_next);
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (!i_empty) n_state = S_MUL;
            S_MUL:  if (r_pv && r_pstep == LastStep) n_state = S_DIV;
            S_DIV: begin
                if (r_j == 3'd5 && ((r_load && (det_zero || hi_part >= mag_d)) ||
                                    (!r_load && r_cnt == 5'd31))) begin
                    n_state = S_OUT;
                end
            end
            S_OUT:  if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pv    <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pv    <= (r_state == S_MUL) && (r_step <= LastStep);
            if (r_state == S_OUT && out_free) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job  <= i_job;
            r_step <= 4'd0;
        end
        if (r_state == S_MUL && r_step <= LastStep) r_step <= r_step + 4'd1;
        r_pstep <= r_step;
        r_prod  <= op_a * op_b;
        if (r_pv) begin
            if (!r_pstep[0]) begin
                r_first <= r_prod;
            end else begin
                r_num[r_pstep[3:1]] <= {r_first[63], r_first} - {r_prod[63], r_prod};
            end
        end
        if (r_state == S_MUL) begin
            r_j    <= 3'd0;
            r_load <= 1'b1;
        end
        if (r_state == S_DIV) begin
            if (r_load) begin
                r_neg <= (num[64] != den[64]);
                r_rem <= hi_part;
                r_lo  <= 32'(mag_n << FRAC_BITS);
                r_q   <= '0;
                r_cnt <= '0;
                if (det_zero || hi_part >= mag_d) begin
                    r_res[r_j] <= det_zero ? '0 : sat_val;
                    r_j        <= r_j + 3'd1;
                end else begin
                    r_load <= 1'b0;
                end
            end else begin
                r_rem <= (shifted >= {1'b0, mag_d}) ? 64'(shifted - {1'b0, mag_d})
                                                   : shifted[63:0];
                r_lo  <= {r_lo[30:0], 1'b0};
                r_q   <= q_next;
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_res[r_j] <= fin_val;
                    r_j        <= r_j + 3'd1;
                    r_load     <= 1'b1;
                end
            end
        end
        if (r_state == S_OUT && out_free) begin
            r_out.idx_a      <= r_job.idx_a;
            r_out.idx_b      <= r_job.idx_b;
            r_out.idx_c      <= r_job.idx_c;
            r_out.degenerate <= (r_num[0] == '0);
            for (int k = 0; k < 3; k++) begin
                r_out.tangent[k]  <= r_res[k];
                r_out.binormal[k] <= r_res[k + 3];
            end
        end
    end

endmodule

[rtl/triangle_tangent_binormal_top.sv]
// Triangle tangent/binormal unit.
// Slave channel (i_s_*): one vertex per item, corners of an indexed triangle
// list in order. Master channel (o_m_*): one item per triangle, carrying the
// three vertex indices, tangent and binormal (Q16.16, saturated); tuser flags
// a zero texture determinant, with both vectors then zero.
// The first two corners are latched. The third corner's
// deltas go into a two-entry queue; the back end pulls them and runs one
// 32x32 multiplier over 14 products, then one radix-2 divider six times
// (its iterations skipped when a component saturates or the triangle is
// degenerate), then loads the output register. The back end works on one
// triangle at a time; meanwhile the front end goes on filling the queue.
// Reset clears the corner count, the queue and the output valid.
// A stalled master holds the result; the back end waits, the queue fills,
// and only then is the third corner of a triangle held off.
module triangle_tangent_binormal_top #(
    parameter int INDEX_BITS = 20,
    parameter int FRAC_BITS  = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // vertex_index[19:0], pos_x, pos_y, pos_z, tex_u, tex_v, zero pad
    input  logic [183:0] i_s_tdata,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // corner_a, corner_b, corner_c, tangent_x/y/z, binormal_x/y/z, zero pad
    output logic [255:0] o_m_tdata,
    // degenerate
    output logic         o_m_tuser
);

    ttb_pkg::t_fix [2:0] pos;
    ttb_pkg::t_fix [1:0] tex;
    ttb_pkg::t_job       f_job;
    ttb_pkg::t_job       q_job;
    ttb_pkg::t_result    res;
    logic                push;
    logic                pop;
    logic                full;
    logic                empty;

    assign pos[0] = i_s_tdata[51:20];
    assign pos[1] = i_s_tdata[83:52];
    assign pos[2] = i_s_tdata[115:84];
    assign tex[0] = i_s_tdata[147:116];
    assign tex[1] = i_s_tdata[179:148];

    ttb_front #(.INDEX_BITS(INDEX_BITS)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_index (i_s_tdata[19:0]),
        .i_pos   (pos),
        .i_tex   (tex),
        .i_full  (full),
        .o_push  (push),
        .o_job   (f_job)
    );

    ttb_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (f_job),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_job   (q_job)
    );

    ttb_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_job   (q_job),
        .o_pop   (pop),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_res   (res)
    );

    assign o_m_tdata = {4'd0,
                        res.binormal[2], res.binormal[1], res.binormal[0],
                        res.tangent[2], res.tangent[1], res.tangent[0],
                        res.idx_c, res.idx_b, res.idx_a};
    assign o_m_tuser = res.degenerate;

endmodule

[rtl/ttb_checker.sv]
`include "assert_macros.svh"

module ttb_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         i_s_tvalid,
    input logic         o_s_tready,
    input logic [183:0] i_s_tdata,
    input logic         o_m_tvalid,
    input logic         i_m_tready,
    input logic [255:0] o_m_tdata,
    input logic         o_m_tuser
);

    `ASSERT_ALL(a_rst_quiet, !i_rst_n |=> !o_m_tvalid, "result valid right after reset")
    `ASSERT_RUN(a_hold_valid, o_m_tvalid && !i_m_tready |=> o_m_tvalid, "result dropped")
    `ASSERT_RUN(a_hold_data, o_m_tvalid && !i_m_tready |=> $stable(o_m_tdata) && $stable(o_m_tuser), "stalled result changed")
    `ASSERT_RUN(a_degen_zero, o_m_tvalid && o_m_tuser |-> o_m_tdata[255:60] == '0, "degenerate with nonzero vectors")

endmodule

bind triangle_tangent_binormal_top ttb_checker u_ttb_checker (.*);
